/* sv/dhip_pkg.sv */
// ----------------------------------------------------------------------------
// dhip_pkg
// Shared constants for the decimal/hex integer parser: result status codes,
// register indexes and the ASCII codes the parser tests against.
// ----------------------------------------------------------------------------
package dhip_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_SYNTAX   = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// register indexes on the configuration port
	localparam logic REG_SIGNED_MODE  = 1'b0;
	localparam logic REG_WIDTH_SELECT = 1'b1;

	// width select codes
	localparam logic [1:0] WSEL_64 = 2'd0;
	localparam logic [1:0] WSEL_32 = 2'd1;

	// ascii codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	// numeric bases
	localparam logic [4:0] BASE_DEC = 5'd10;
	localparam logic [4:0] BASE_HEX = 5'd16;

endpackage

/* sv/dec_hex_integer_parser.sv */
// ----------------------------------------------------------------------------
// dec_hex_integer_parser
// Character-serial parser of decimal and 0x/0X hex integers into 64 bits,
// with per-digit overflow check, optional sign and a result range check.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per beat on the input channel and
// returns one result beat (value, status) when the terminating NUL arrives;
// all other characters give no result. Per character, the combinational
// digit shift-add and overflow check, and at NUL the range check
// and negation, sit between the parse state registers and the result
// register, so a new character is taken every cycle while the result register
// is empty or being drained. A waiting result stalls input only when the
// result register is full and the sink is not ready. signed_mode and
// width_select are written over the APB port at byte addresses 0 and 4 and
// should only be changed while no string is in progress.
module dec_hex_integer_parser (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// character input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic [1:0]  status
);

	typedef enum logic [3:0] {
		PH_START  = 4'd0,
		PH_PLUS   = 4'd1,
		PH_NUM    = 4'd2,
		PH_BLANKS = 4'd3,
		PH_ZERO   = 4'd4,
		PH_HEX    = 4'd5,
		PH_DEC    = 4'd6,
		PH_TRAIL  = 4'd7,
		PH_ERR    = 4'd8
	} phase_t;

	logic        signed_mode_q;
	logic [1:0]  width_select_q;

	phase_t            phase_q, phase_d;
	logic [63:0]       acc_q, acc_d;
	logic              neg_q, neg_d;
	dhip_pkg::status_t err_q, err_d;

	logic              emit;
	logic [63:0]       emit_value;
	dhip_pkg::status_t emit_status;

	logic              out_valid_q;
	logic [63:0]       value_q;
	dhip_pkg::status_t status_q;

	logic in_accept;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q  <= 1'b0;
			width_select_q <= 2'd0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == dhip_pkg::REG_SIGNED_MODE) begin
				signed_mode_q <= pwdata[0];
			end else begin
				width_select_q <= pwdata[1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == dhip_pkg::REG_SIGNED_MODE) begin
			prdata = {31'd0, signed_mode_q};
		end else begin
			prdata = {30'd0, width_select_q};
		end
	end

	// character classes
	logic       is_blank, is_nul, is_dec, is_hex_uc, is_hex_lc, is_x;
	logic [3:0] dec_digit, hex_digit;

	always_comb begin
		is_nul    = (char_byte == dhip_pkg::CH_NUL);
		is_blank  = (char_byte == dhip_pkg::CH_SPACE) || (char_byte == dhip_pkg::CH_TAB);
		is_dec    = (char_byte >= dhip_pkg::CH_0) && (char_byte <= dhip_pkg::CH_9);
		is_hex_uc = (char_byte >= dhip_pkg::CH_UA) && (char_byte <= dhip_pkg::CH_UF);
		is_hex_lc = (char_byte >= dhip_pkg::CH_LA) && (char_byte <= dhip_pkg::CH_LF);
		is_x      = (char_byte == dhip_pkg::CH_LX) || (char_byte == dhip_pkg::CH_UX);
		dec_digit = 4'(char_byte - dhip_pkg::CH_0);
		if (is_hex_uc) begin
			hex_digit = 4'(char_byte - dhip_pkg::CH_UA + 8'd10);
		end else if (is_hex_lc) begin
			hex_digit = 4'(char_byte - dhip_pkg::CH_LA + 8'd10);
		end else begin
			hex_digit = dec_digit;
		end
	end

	// digit shift-add with carry-out as overflow flag
	logic        use_hex;
	logic [67:0] acc_ext, mul_res, sum_res;
	logic        dig_ovf;

	always_comb begin
		use_hex = (phase_q == PH_HEX);
		acc_ext = {4'd0, acc_q};
		if (use_hex) begin
			mul_res = acc_ext << 4;
			sum_res = mul_res + {64'd0, hex_digit};
		end else begin
			mul_res = (acc_ext << 3) + (acc_ext << 1);
			sum_res = mul_res + {64'd0, dec_digit};
		end
		dig_ovf = (sum_res[67:64] != 4'd0);
	end

	// range limit for the final check
	logic [63:0] lim;
	logic        range_ovf;
	logic [63:0] final_value;

	always_comb begin
		if (signed_mode_q) begin
			case (width_select_q)
				dhip_pkg::WSEL_64: lim = 64'h7FFF_FFFF_FFFF_FFFF + {63'd0, neg_q};
				dhip_pkg::WSEL_32: lim = 64'h0000_0000_7FFF_FFFF + {63'd0, neg_q};
				default:           lim = 64'h0000_0000_0000_7FFF + {63'd0, neg_q};
			endcase
		end else begin
			case (width_select_q)
				dhip_pkg::WSEL_64: lim = 64'hFFFF_FFFF_FFFF_FFFF;
				dhip_pkg::WSEL_32: lim = 64'h0000_0000_FFFF_FFFF;
				default:           lim = 64'h0000_0000_0000_FFFF;
			endcase
		end
		range_ovf   = (acc_q > lim);
		final_value = neg_q ? (64'd0 - acc_q) : acc_q;
	end

	// next parse state for one character
	phase_t ph;
	logic   taken;
	logic   tail;

	always_comb begin
		phase_d     = phase_q;
		acc_d       = acc_q;
		neg_d       = neg_q;
		err_d       = err_q;
		emit        = 1'b0;
		emit_value  = 64'd0;
		emit_status = dhip_pkg::ST_OK;
		ph          = phase_q;
		taken       = 1'b0;
		tail        = 1'b0;

		// sign prefix
		if (phase_q == PH_START) begin
			ph      = PH_NUM;
			phase_d = PH_NUM;
			if (signed_mode_q) begin
				if (char_byte == dhip_pkg::CH_PLUS) begin
					phase_d = PH_PLUS;
					taken   = 1'b1;
				end else if (char_byte == dhip_pkg::CH_MINUS) begin
					neg_d = 1'b1;
					taken = 1'b1;
				end
			end
		end else if (phase_q == PH_PLUS) begin
			ph      = PH_NUM;
			phase_d = PH_NUM;
			if (char_byte == dhip_pkg::CH_MINUS) begin
				neg_d = 1'b1;
				taken = 1'b1;
			end
		end

		if (!taken) begin
			case (ph)
				PH_NUM, PH_BLANKS: begin
					if (is_nul) begin
						emit        = 1'b1;
						emit_status = dhip_pkg::ST_EMPTY;
					end else if (is_blank) begin
						phase_d = PH_BLANKS;
					end else if (ph == PH_NUM && char_byte == dhip_pkg::CH_0) begin
						acc_d   = 64'd0;
						phase_d = PH_ZERO;
					end else if (ph == PH_NUM && char_byte >= dhip_pkg::CH_1
						&& char_byte <= dhip_pkg::CH_9) begin
						acc_d   = {60'd0, dec_digit};
						phase_d = PH_DEC;
					end else begin
						err_d   = dhip_pkg::ST_SYNTAX;
						phase_d = PH_ERR;
					end
				end
				PH_ZERO: begin
					if (is_x) begin
						phase_d = PH_HEX;
					end else if (is_dec) begin
						if (dig_ovf) begin
							err_d   = dhip_pkg::ST_OVERFLOW;
							phase_d = PH_ERR;
						end else begin
							acc_d   = sum_res[63:0];
							phase_d = PH_DEC;
						end
					end else begin
						tail = 1'b1;
					end
				end
				PH_HEX, PH_DEC: begin
					if (is_dec || (ph == PH_HEX && (is_hex_uc || is_hex_lc))) begin
						if (dig_ovf) begin
							err_d   = dhip_pkg::ST_OVERFLOW;
							phase_d = PH_ERR;
						end else begin
							acc_d = sum_res[63:0];
						end
					end else begin
						tail = 1'b1;
					end
				end
				PH_TRAIL: begin
					tail = 1'b1;
				end
				default: begin
					// error held until end of string
					if (is_nul) begin
						emit        = 1'b1;
						emit_status = (err_q == dhip_pkg::ST_OK) ? dhip_pkg::ST_SYNTAX : err_q;
					end
				end
			endcase
		end

		// after digits: end of string, trailing blanks or syntax error
		if (tail) begin
			if (is_nul) begin
				emit = 1'b1;
				if (range_ovf) begin
					emit_status = dhip_pkg::ST_OVERFLOW;
				end else begin
					emit_value  = final_value;
					emit_status = dhip_pkg::ST_OK;
				end
			end else if (is_blank) begin
				phase_d = PH_TRAIL;
			end else begin
				err_d   = dhip_pkg::ST_SYNTAX;
				phase_d = PH_ERR;
			end
		end

		// a result restarts the string
		if (emit) begin
			phase_d = PH_START;
			acc_d   = 64'd0;
			neg_d   = 1'b0;
			err_d   = dhip_pkg::ST_OK;
		end
	end

	// input handshake: blocked only by a full, stalled result register
	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	// parse state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			acc_q       <= 64'd0;
			neg_q       <= 1'b0;
			err_q       <= dhip_pkg::ST_OK;
			out_valid_q <= 1'b0;
			value_q     <= 64'd0;
			status_q    <= dhip_pkg::ST_OK;
		end else begin
			if (in_accept) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				err_q   <= err_d;
			end
			if (in_accept && emit) begin
				out_valid_q <= 1'b1;
				value_q     <= emit_value;
				status_q    <= emit_status;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

endmodule
